// ----- design/ccfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ccfr_pkg
// Shared types, sizes and the CRC-16/X-25 byte update for the COBS frame
// receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ccfr_pkg;

  // Frame store depth in bytes.
  localparam int unsigned FRAME_BYTES = 512;
  localparam int unsigned ADDR_W      = $clog2(FRAME_BYTES);
  localparam int unsigned LEN_W       = $clog2(FRAME_BYTES + 1);

  localparam int unsigned HDR_BYTES = 5;
  localparam int unsigned CRC_BYTES = 2;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RIDX_W  = 9;
  localparam int unsigned PLEN_W  = 9;
  localparam int unsigned HLEN_W  = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CRC_W   = 16;

  // Read position = header size + payload index.
  localparam int unsigned POS_W = ((LEN_W > RIDX_W) ? LEN_W : RIDX_W) + 1;
  // Width for comparing declared against stored frame length.
  localparam int unsigned CMP_W = (LEN_W > HLEN_W + 1) ? LEN_W : HLEN_W + 1;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 136;
  localparam int unsigned EV_W       = 3;

  typedef enum logic [EV_W-1:0] {
    EV_BYTE    = 3'd0,
    EV_OK      = 3'd1,
    EV_FRAMING = 3'd2,
    EV_CRC     = 3'd3,
    EV_EMPTY   = 3'd4,
    EV_READ    = 3'd5
  } event_e;

  // Decoder to frame checker.
  typedef struct packed {
    logic              emit;      // one decoded byte to append
    logic [BYTE_W-1:0] data;
    logic              delim;     // zero byte on the wire
    logic              cobs_err;  // zero byte inside a COBS block
  } dec_t;

  function automatic logic [CRC_W-1:0] crc16_x25_byte(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/ccfr_cobs_dec.sv -----
// ----------------------------------------------------------------------------
// ccfr_cobs_dec
// COBS block decoder: tracks the code byte countdown and the implied zero
// between blocks, flags delimiters and zeros that fall inside a block.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfr_cobs_dec (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,     // wire byte transfer
  input  wire logic [ccfr_pkg::BYTE_W-1:0] byte_i,
  output ccfr_pkg::dec_t                 dec_o
);
  import ccfr_pkg::*;

  logic [BYTE_W-1:0] remain_q, remain_d;
  logic              full_run_q, full_run_d;
  logic              zero_pend_q, zero_pend_d;

  always_comb begin
    dec_o       = '0;
    remain_d    = remain_q;
    full_run_d  = full_run_q;
    zero_pend_d = zero_pend_q;
    if (byte_i == '0) begin
      dec_o.delim    = 1'b1;
      dec_o.cobs_err = (remain_q != '0);
      remain_d       = '0;
      full_run_d     = 1'b0;
      zero_pend_d    = 1'b0;
    end else if (remain_q == '0) begin
      // code byte: flush the zero owed by the previous short block
      dec_o.emit  = zero_pend_q;
      dec_o.data  = '0;
      full_run_d  = (byte_i == '1);
      remain_d    = byte_i - BYTE_W'(1);
      zero_pend_d = (byte_i == BYTE_W'(1));
    end else begin
      dec_o.emit = 1'b1;
      dec_o.data = byte_i;
      remain_d   = remain_q - BYTE_W'(1);
      if (remain_d == '0) begin
        zero_pend_d = !full_run_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q    <= '0;
      full_run_q  <= 1'b0;
      zero_pend_q <= 1'b0;
    end else if (en_i) begin
      remain_q    <= remain_d;
      full_run_q  <= full_run_d;
      zero_pend_q <= zero_pend_d;
    end
  end

  // An implied zero is only owed between blocks.
  a_pend_between_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_pend_q |-> (remain_q == '0))
    else $error("zero pending inside a block");

endmodule

`default_nettype wire

// ----- design/ccfr_frame_chk.sv -----
// ----------------------------------------------------------------------------
// ccfr_frame_chk
// Frame store, running CRC with two-byte holdback, header capture, frame
// verdict at the delimiter and outcome counters.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfr_frame_chk (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,        // wire byte transfer
  input  wire ccfr_pkg::dec_t              dec_i,
  input  wire logic [ccfr_pkg::BYTE_W-1:0] exp_ver_i,
  input  wire logic                        rd_en_i,     // read transfer
  input  wire logic [ccfr_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [ccfr_pkg::BYTE_W-1:0]      rd_data_o,
  output ccfr_pkg::event_e                 ev_o,
  output logic [ccfr_pkg::BYTE_W-1:0]      msg_type_o,
  output logic [ccfr_pkg::BYTE_W-1:0]      seq_num_o,
  output logic [ccfr_pkg::PLEN_W-1:0]      plen_o,
  output logic [ccfr_pkg::CNT_W-1:0]       good_cnt_o,
  output logic [ccfr_pkg::CNT_W-1:0]       framing_cnt_o,
  output logic [ccfr_pkg::CNT_W-1:0]       crc_cnt_o
);
  import ccfr_pkg::*;

  logic [BYTE_W-1:0] mem [FRAME_BYTES];
  logic [BYTE_W-1:0] rd_q;

  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic [CRC_W-1:0]  crc_q, crc_d;
  logic [CRC_W-1:0]  tail_q, tail_d;
  logic [HLEN_W-1:0] hlen_q, hlen_d;
  logic [BYTE_W-1:0] ver_q, ver_d;
  logic [BYTE_W-1:0] type_q, type_d;
  logic [BYTE_W-1:0] seq_q, seq_d;
  logic [CNT_W-1:0]  good_q, framing_q, crcerr_q;

  logic              wr_en;
  logic              inc_good, inc_framing, inc_crc;
  logic [CMP_W-1:0]  want_len;
  logic [CRC_W-1:0]  rx_crc;

  assign want_len = CMP_W'(hlen_q) + CMP_W'(HDR_BYTES + CRC_BYTES);
  assign rx_crc   = {tail_q[BYTE_W-1:0], tail_q[CRC_W-1:BYTE_W]};

  always_comb begin
    len_d       = len_q;
    ovf_d       = ovf_q;
    crc_d       = crc_q;
    tail_d      = tail_q;
    hlen_d      = hlen_q;
    ver_d       = ver_q;
    type_d      = type_q;
    seq_d       = seq_q;
    wr_en       = 1'b0;
    inc_good    = 1'b0;
    inc_framing = 1'b0;
    inc_crc     = 1'b0;
    ev_o        = EV_BYTE;
    msg_type_o  = '0;
    seq_num_o   = '0;
    plen_o      = '0;

    if (dec_i.delim) begin
      if (dec_i.cobs_err) begin
        inc_framing = 1'b1;
        ev_o        = EV_FRAMING;
      end else if (len_q == '0) begin
        ev_o = EV_EMPTY;
      end else if (ovf_q || (len_q < LEN_W'(HDR_BYTES + CRC_BYTES)) ||
                   (CMP_W'(len_q) != want_len) || (ver_q != exp_ver_i)) begin
        inc_framing = 1'b1;
        ev_o        = EV_FRAMING;
      end else if (rx_crc != (crc_q ^ CRC_INIT)) begin
        inc_crc = 1'b1;
        ev_o    = EV_CRC;
      end else begin
        inc_good   = 1'b1;
        ev_o       = EV_OK;
        msg_type_o = type_q;
        seq_num_o  = seq_q;
        plen_o     = hlen_q[PLEN_W-1:0];
      end
      len_d  = '0;
      ovf_d  = 1'b0;
      crc_d  = CRC_INIT;
      tail_d = '0;
      hlen_d = '0;
    end else if (dec_i.emit) begin
      if (ovf_q || (len_q >= LEN_W'(FRAME_BYTES))) begin
        ovf_d = 1'b1;
      end else begin
        wr_en = 1'b1;
        // CRC trails the stream by two bytes so the tail can be compared
        if (len_q >= LEN_W'(2)) begin
          crc_d = crc16_x25_byte(crc_q, tail_q[CRC_W-1:BYTE_W]);
        end
        tail_d = {tail_q[BYTE_W-1:0], dec_i.data};
        case (len_q)
          LEN_W'(0): ver_d  = dec_i.data;
          LEN_W'(1): type_d = dec_i.data;
          LEN_W'(2): seq_d  = dec_i.data;
          LEN_W'(3): hlen_d = {{(HLEN_W-BYTE_W){1'b0}}, dec_i.data};
          LEN_W'(4): hlen_d = {dec_i.data, hlen_q[BYTE_W-1:0]};
          default:   hlen_d = hlen_q;
        endcase
        len_d = len_q + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      ovf_q     <= 1'b0;
      crc_q     <= CRC_INIT;
      tail_q    <= '0;
      hlen_q    <= '0;
      good_q    <= '0;
      framing_q <= '0;
      crcerr_q  <= '0;
    end else if (en_i) begin
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      crc_q     <= crc_d;
      tail_q    <= tail_d;
      hlen_q    <= hlen_d;
      good_q    <= good_q + CNT_W'(inc_good);
      framing_q <= framing_q + CNT_W'(inc_framing);
      crcerr_q  <= crcerr_q + CNT_W'(inc_crc);
    end
  end

  // header bytes only matter once the frame is long enough to pass
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ver_q  <= ver_d;
      type_q <= type_d;
      seq_q  <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && wr_en) begin
      mem[len_q[ADDR_W-1:0]] <= dec_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o     = rd_q;
  assign good_cnt_o    = good_q;
  assign framing_cnt_o = framing_q;
  assign crc_cnt_o     = crcerr_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(FRAME_BYTES))
    else $error("frame length beyond store");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (len_q == LEN_W'(FRAME_BYTES)))
    else $error("overflow with room left in store");

  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> ($countones({good_q != $past(good_q), framing_q != $past(framing_q),
                          crcerr_q != $past(crcerr_q)}) <= 1))
    else $error("more than one outcome counted for one byte");

endmodule

`default_nettype wire

// ----- design/cobs_crc_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// cobs_crc_frame_receiver
// COBS deframer with CRC-16/X-25 frame check and payload byte readout.
// ----------------------------------------------------------------------------
// One item (a wire byte or a read command) is taken every clock cycle while
// the input side is ready; its result is registered into the output register.
// The input side stays ready while that register is empty or being drained,
// so throughput is one item per cycle. The CRC is a single byte-wide update
// per cycle and the frame store is a 512 x 8 memory with one write port and
// one registered read port. A read returns payload byte read_index of the last
// frame stored (header skipped); reading an entry never written gives undefined
// data. The version register may be written only while the block is idle.
`default_nettype none

module cobs_crc_frame_receiver (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // config: expected_version
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ccfr_pkg::BYTE_W-1:0]       cfg_data_i,
  // input stream
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // [7:0] wire_byte, [16:8] read_index, [23:17] zero
  input  wire logic [ccfr_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // [0] command
  input  wire logic                              s_axis_tuser_i,
  // result stream
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [7:0] msg_type, [15:8] seq_num, [24:16] payload_len, [32:25] read_byte,
  // [64:33] good_frames, [96:65] bad_framing_count, [128:97] bad_crc_count,
  // [135:129] zero
  output logic [ccfr_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o,
  // [2:0] event_res
  output logic [ccfr_pkg::EV_W-1:0]              m_axis_tuser_o
);
  import ccfr_pkg::*;

  logic              accept, feed_en, read_en;
  logic [BYTE_W-1:0] wire_byte;
  logic [RIDX_W-1:0] read_index;
  logic [POS_W-1:0]  rd_pos;
  logic              rd_in_range;

  dec_t              dec;
  event_e            chk_ev;
  logic [BYTE_W-1:0] chk_type, chk_seq, rd_data;
  logic [PLEN_W-1:0] chk_plen;
  logic [CNT_W-1:0]  good_cnt, framing_cnt, crc_cnt;

  logic              vld_q;
  event_e            ev_q;
  logic [BYTE_W-1:0] type_q, seq_q;
  logic [PLEN_W-1:0] plen_q;
  logic              rd_sel_q;
  logic [BYTE_W-1:0] exp_ver_q;
  logic [BYTE_W-1:0] read_byte;

  assign wire_byte  = s_axis_tdata_i[BYTE_W-1:0];
  assign read_index = s_axis_tdata_i[BYTE_W+RIDX_W-1:BYTE_W];

  assign s_axis_tready_o = !vld_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign feed_en         = accept && !s_axis_tuser_i;
  assign read_en         = accept && s_axis_tuser_i;

  assign rd_pos      = POS_W'(HDR_BYTES) + POS_W'(read_index);
  assign rd_in_range = (rd_pos < POS_W'(FRAME_BYTES));

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q <= BYTE_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      exp_ver_q <= cfg_data_i;
    end
  end

  ccfr_cobs_dec u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (feed_en),
    .byte_i (wire_byte),
    .dec_o  (dec)
  );

  ccfr_frame_chk u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (feed_en),
    .dec_i         (dec),
    .exp_ver_i     (exp_ver_q),
    .rd_en_i       (read_en),
    .rd_addr_i     (rd_pos[ADDR_W-1:0]),
    .rd_data_o     (rd_data),
    .ev_o          (chk_ev),
    .msg_type_o    (chk_type),
    .seq_num_o     (chk_seq),
    .plen_o        (chk_plen),
    .good_cnt_o    (good_cnt),
    .framing_cnt_o (framing_cnt),
    .crc_cnt_o     (crc_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (s_axis_tuser_i) begin
        ev_q     <= EV_READ;
        type_q   <= '0;
        seq_q    <= '0;
        plen_q   <= '0;
        rd_sel_q <= rd_in_range;
      end else begin
        ev_q     <= chk_ev;
        type_q   <= chk_type;
        seq_q    <= chk_seq;
        plen_q   <= chk_plen;
        rd_sel_q <= 1'b0;
      end
    end
  end

  // counters change only on a transfer in, so they match the held result
  assign read_byte       = rd_sel_q ? rd_data : '0;
  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tuser_o  = ev_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - 3*CNT_W - 3*BYTE_W - PLEN_W){1'b0}},
                            crc_cnt, framing_cnt, good_cnt,
                            read_byte, plen_q, seq_q, type_q};

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted item left no result");

  a_read_byte_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != EV_READ)) |-> (read_byte == '0))
    else $error("read data on a non-read result");

endmodule

`default_nettype wire
